// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the texel band classifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/ttbc_pkg.sv =====
// Shared constants, codes and control structs of the texel band classifier
package ttbc_pkg;

    // Default sizes of the height map and of the upsampling factor
    localparam int MAX_SIDE_DEF = 64;
    localparam int MAX_RES_DEF  = 8;

    // Register reset values and lower limits
    localparam int SIDE_RESET = 64;
    localparam int RES_RESET  = 2;
    localparam int SIDE_MIN   = 2;
    localparam int RES_MIN    = 1;

    // Configuration port layout
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int SIDE_CFG_W = 7;
    localparam int RES_CFG_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RES  = 2'd1;

    // Request commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Payload widths
    localparam int HEIGHT_W = 8;
    localparam int TEXEL_W  = 9;
    localparam int BAND_W   = 2;

    // Terrain bands
    localparam logic [BAND_W-1:0] BAND_WATER    = 2'd0;
    localparam logic [BAND_W-1:0] BAND_SAND     = 2'd1;
    localparam logic [BAND_W-1:0] BAND_GRASS    = 2'd2;
    localparam logic [BAND_W-1:0] BAND_MOUNTAIN = 2'd3;

    // Band thresholds in byte units (0.8, 0.4 and 0.2 of 255)
    localparam int THR_MOUNTAIN = 204;
    localparam int THR_GRASS    = 102;
    localparam int THR_SAND     = 51;

    // Request control from the front end to the sequencer
    typedef struct packed {
        logic cmd;
        logic oor;
    } ttbc_op_ctl_t;

    // Control of one token from the sequencer to the blend unit
    typedef struct packed {
        logic first;
        logic last;
        logic oor;
    } ttbc_tok_ctl_t;

endpackage

// ===== rtl/ttbc_ifs.sv =====
// Request, response and configuration channel interfaces
interface ttbc_req_if;
    import ttbc_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd;
    logic [HEIGHT_W-1:0] height;
    logic [TEXEL_W-1:0]  texel_x;
    logic [TEXEL_W-1:0]  texel_y;

    modport source (output valid, cmd, height, texel_x, texel_y, input ready);
    modport sink (input valid, cmd, height, texel_x, texel_y, output ready);
endinterface

interface ttbc_rsp_if;
    import ttbc_pkg::*;

    logic               valid;
    logic               ready;
    logic [BAND_W-1:0]  band;
    logic [TEXEL_W-1:0] echo_x;
    logic [TEXEL_W-1:0] echo_y;
    logic               out_of_range;

    modport source (output valid, band, echo_x, echo_y, out_of_range, input ready);
    modport sink (input valid, band, echo_x, echo_y, out_of_range, output ready);
endinterface

interface ttbc_cfg_if;
    import ttbc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ttbc_ram.sv =====
// Generic single-port RAM with registered read data
module ttbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ttbc_front.sv =====
// Request intake: coordinate split into sample index and remainder, range check
module ttbc_front #(
    parameter int MAX_SIDE = ttbc_pkg::MAX_SIDE_DEF,
    parameter int MAX_RES  = ttbc_pkg::MAX_RES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ttbc_req_if.sink                           req,
    input  logic [$clog2(MAX_SIDE+1)-1:0]      side,
    input  logic [$clog2(MAX_RES+1)-1:0]       res,
    output logic                               op_valid,
    input  logic                               op_ready,
    output ttbc_pkg::ttbc_op_ctl_t             op_ctl,
    output logic [ttbc_pkg::HEIGHT_W-1:0]      op_height,
    output logic [ttbc_pkg::TEXEL_W-1:0]       op_x,
    output logic [ttbc_pkg::TEXEL_W-1:0]       op_y,
    output logic [$clog2(MAX_SIDE)-1:0]        op_px,
    output logic [$clog2(MAX_RES+1)-1:0]       op_rx,
    output logic [$clog2(MAX_SIDE)-1:0]        op_py,
    output logic [$clog2(MAX_RES+1)-1:0]       op_ry
);
    import ttbc_pkg::*;

    localparam int SW          = $clog2(MAX_SIDE + 1);
    localparam int RW          = $clog2(MAX_RES + 1);
    localparam int CW          = $clog2(MAX_SIDE);
    localparam int GW          = SW + RW;
    localparam int RECIP_SHIFT = 12;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = TEXEL_W + RECIP_W;
    localparam int QR_W        = TEXEL_W + RW;

    // Scaled reciprocal floor(4096 / r); the estimate is exact or one low
    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [4:0] r);
        logic [RECIP_W-1:0] v;
        case (r)
            5'd1:    v = 13'd4096;
            5'd2:    v = 13'd2048;
            5'd3:    v = 13'd1365;
            5'd4:    v = 13'd1024;
            5'd5:    v = 13'd819;
            5'd6:    v = 13'd682;
            5'd7:    v = 13'd585;
            5'd8:    v = 13'd512;
            5'd9:    v = 13'd455;
            5'd10:   v = 13'd409;
            5'd11:   v = 13'd372;
            5'd12:   v = 13'd341;
            5'd13:   v = 13'd315;
            5'd14:   v = 13'd292;
            5'd15:   v = 13'd273;
            5'd16:   v = 13'd256;
            default: v = 13'd4096;
        endcase
        return v;
    endfunction

    // Stage A registers
    logic                a_valid_reg;
    logic                a_cmd_reg;
    logic [HEIGHT_W-1:0] a_height_reg;
    logic [TEXEL_W-1:0]  a_x_reg;
    logic [TEXEL_W-1:0]  a_y_reg;

    // Stage B registers
    logic                b_valid_reg;
    ttbc_op_ctl_t        b_ctl_reg;
    logic [HEIGHT_W-1:0] b_height_reg;
    logic [TEXEL_W-1:0]  b_x_reg;
    logic [TEXEL_W-1:0]  b_y_reg;
    logic [TEXEL_W-1:0]  b_qx_reg;
    logic [TEXEL_W-1:0]  b_qy_reg;

    logic                a_free;
    logic                a_move;
    logic                b_free;
    logic [RECIP_W-1:0]  recip;
    logic [PROD_W-1:0]   prod_x;
    logic [PROD_W-1:0]   prod_y;
    logic [GW-1:0]       grid;
    logic                a_oor;
    logic [QR_W-1:0]     qr_x;
    logic [QR_W-1:0]     qr_y;
    logic [TEXEL_W-1:0]  rem_x;
    logic [TEXEL_W-1:0]  rem_y;
    logic                fix_x;
    logic                fix_y;
    logic [TEXEL_W-1:0]  q_x;
    logic [TEXEL_W-1:0]  q_y;
    logic [TEXEL_W-1:0]  r_x;
    logic [TEXEL_W-1:0]  r_y;

    // Stall handshake across the two stages
    assign b_free    = !b_valid_reg || op_ready;
    assign a_free    = !a_valid_reg || b_free;
    assign a_move    = a_valid_reg && b_free;
    assign req.ready = a_free;

    // Quotient estimate by reciprocal and grid range check
    assign recip  = recip_lookup(5'(res));
    assign prod_x = PROD_W'(a_x_reg) * PROD_W'(recip);
    assign prod_y = PROD_W'(a_y_reg) * PROD_W'(recip);
    assign grid   = GW'(side - 1'b1) * GW'(res) + GW'(1);
    assign a_oor  = (a_cmd_reg == CMD_QUERY)
                 && (((TEXEL_W + GW)'(a_x_reg) >= (TEXEL_W + GW)'(grid))
                  || ((TEXEL_W + GW)'(a_y_reg) >= (TEXEL_W + GW)'(grid)));

    // Capture a new request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_free)
        begin
            a_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && a_free)
        begin
            a_cmd_reg    <= req.cmd;
            a_height_reg <= req.height;
            a_x_reg      <= req.texel_x;
            a_y_reg      <= req.texel_y;
        end
    end

    // Advance into stage B
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_free)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_ctl_reg.cmd <= a_cmd_reg;
            b_ctl_reg.oor <= a_oor;
            b_height_reg  <= a_height_reg;
            b_x_reg       <= a_x_reg;
            b_y_reg       <= a_y_reg;
            b_qx_reg      <= prod_x[RECIP_SHIFT +: TEXEL_W];
            b_qy_reg      <= prod_y[RECIP_SHIFT +: TEXEL_W];
        end
    end

    // Correct the quotient estimate by one step
    assign qr_x  = QR_W'(b_qx_reg) * QR_W'(res);
    assign qr_y  = QR_W'(b_qy_reg) * QR_W'(res);
    assign rem_x = b_x_reg - qr_x[TEXEL_W-1:0];
    assign rem_y = b_y_reg - qr_y[TEXEL_W-1:0];
    assign fix_x = rem_x >= TEXEL_W'(res);
    assign fix_y = rem_y >= TEXEL_W'(res);
    assign q_x   = fix_x ? b_qx_reg + 1'b1 : b_qx_reg;
    assign q_y   = fix_y ? b_qy_reg + 1'b1 : b_qy_reg;
    assign r_x   = fix_x ? rem_x - TEXEL_W'(res) : rem_x;
    assign r_y   = fix_y ? rem_y - TEXEL_W'(res) : rem_y;

    assign op_valid  = b_valid_reg;
    assign op_ctl    = b_ctl_reg;
    assign op_height = b_height_reg;
    assign op_x      = b_x_reg;
    assign op_y      = b_y_reg;
    assign op_px     = q_x[CW-1:0];
    assign op_py     = q_y[CW-1:0];
    assign op_rx     = r_x[RW-1:0];
    assign op_ry     = r_y[RW-1:0];

endmodule

// ===== rtl/ttbc_seq.sv =====
// Height store sequencer: sample writes, four neighbor reads per in-range query, weights
`include "assert_macros.svh"

module ttbc_seq #(
    parameter int MAX_SIDE = ttbc_pkg::MAX_SIDE_DEF,
    parameter int MAX_RES  = ttbc_pkg::MAX_RES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [$clog2(MAX_SIDE+1)-1:0]         side,
    input  logic [$clog2(MAX_RES+1)-1:0]          res,
    input  logic                                  op_valid,
    output logic                                  op_ready,
    input  ttbc_pkg::ttbc_op_ctl_t                op_ctl,
    input  logic [ttbc_pkg::HEIGHT_W-1:0]         op_height,
    input  logic [ttbc_pkg::TEXEL_W-1:0]          op_x,
    input  logic [ttbc_pkg::TEXEL_W-1:0]          op_y,
    input  logic [$clog2(MAX_SIDE)-1:0]           op_px,
    input  logic [$clog2(MAX_RES+1)-1:0]          op_rx,
    input  logic [$clog2(MAX_SIDE)-1:0]           op_py,
    input  logic [$clog2(MAX_RES+1)-1:0]          op_ry,
    input  logic                                  adv,
    output logic                                  tok_valid,
    output ttbc_pkg::ttbc_tok_ctl_t               tok_ctl,
    output logic [2*($clog2(MAX_RES+1)+1)-1:0]    tok_weight,
    output logic [ttbc_pkg::TEXEL_W-1:0]          tok_x,
    output logic [ttbc_pkg::TEXEL_W-1:0]          tok_y,
    output logic [ttbc_pkg::HEIGHT_W-1:0]         rdata
);
    import ttbc_pkg::*;

    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int RW    = $clog2(MAX_RES + 1);
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int KW    = RW + 1;
    localparam int WW    = 2 * KW;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = 2 * SW;
    localparam int MW    = CW + SW;

    // Current request
    logic                busy_reg;
    ttbc_op_ctl_t        cur_ctl_reg;
    logic [HEIGHT_W-1:0] cur_height_reg;
    logic [TEXEL_W-1:0]  cur_x_reg;
    logic [TEXEL_W-1:0]  cur_y_reg;
    logic [CW-1:0]       cur_px_reg;
    logic [RW-1:0]       cur_rx_reg;
    logic [CW-1:0]       cur_py_reg;
    logic [RW-1:0]       cur_ry_reg;
    logic [1:0]          step_reg;
    logic [AW-1:0]       pos_reg;
    logic [AW-1:0]       pos_next;

    // Token aligned with the read data
    logic                tok_valid_reg;
    ttbc_tok_ctl_t       tok_ctl_reg;
    logic [WW-1:0]       tok_weight_reg;
    logic [TEXEL_W-1:0]  tok_x_reg;
    logic [TEXEL_W-1:0]  tok_y_reg;

    logic                is_load;
    logic                is_read;
    logic                last_step;
    logic                take;
    logic [CW-1:0]       nx;
    logic [CW-1:0]       ny;
    logic [CW-1:0]       col;
    logic [CW-1:0]       row;
    logic [MW-1:0]       lin_addr;
    logic [TW-1:0]       total;
    logic [AW-1:0]       pos_cur;
    logic [TW-1:0]       pos_inc;
    logic                ram_en;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [KW-1:0]       k;
    logic [KW-1:0]       wx;
    logic [KW-1:0]       wy;
    logic [WW-1:0]       weight;

    // Decode the request in service
    assign is_load   = busy_reg && (cur_ctl_reg.cmd == CMD_LOAD);
    assign is_read   = busy_reg && (cur_ctl_reg.cmd == CMD_QUERY) && !cur_ctl_reg.oor;
    assign last_step = (cur_ctl_reg.cmd == CMD_LOAD) || cur_ctl_reg.oor
                    || (step_reg == 2'd3);
    assign op_ready  = adv && (!busy_reg || last_step);
    assign take      = op_valid && op_ready;

    // Neighbor coordinates, clamped at the far edge
    assign nx  = (((CW + 1)'(cur_px_reg) + 1'b1) == (CW + 1)'(side)) ? cur_px_reg
               : cur_px_reg + 1'b1;
    assign ny  = (((CW + 1)'(cur_py_reg) + 1'b1) == (CW + 1)'(side)) ? cur_py_reg
               : cur_py_reg + 1'b1;
    assign col = step_reg[0] ? nx : cur_px_reg;
    assign row = step_reg[1] ? ny : cur_py_reg;
    assign lin_addr = MW'(row) * MW'(side) + MW'(col);

    // Raster load position with wrap after side*side samples
    assign total    = TW'(side) * TW'(side);
    assign pos_cur  = (TW'(pos_reg) >= total) ? '0 : pos_reg;
    assign pos_inc  = TW'(pos_cur) + 1'b1;
    assign pos_next = (pos_inc >= total) ? '0 : pos_inc[AW-1:0];

    // Memory port: one write per load, one read per in-range query step
    assign ram_en   = adv && (is_load || is_read);
    assign ram_we   = is_load;
    assign ram_addr = is_load ? pos_cur : lin_addr[AW-1:0];

    ttbc_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_height_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cur_height_reg),
        .rdata (rdata)
    );

    // Bilinear weight of the neighbor read in this step
    assign k      = KW'(res) + 1'b1;
    assign wx     = step_reg[0] ? KW'(cur_rx_reg) : k - KW'(cur_rx_reg);
    assign wy     = step_reg[1] ? KW'(cur_ry_reg) : k - KW'(cur_ry_reg);
    assign weight = WW'(wx) * WW'(wy);

    // Control: busy flag, step counter, load position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 2'd0;
            pos_reg       <= '0;
            tok_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (!busy_reg || last_step)
            begin
                busy_reg <= op_valid;
            end
            if (is_read)
            begin
                step_reg <= step_reg + 2'd1;
            end
            if (is_load)
            begin
                pos_reg <= pos_next;
            end
            tok_valid_reg <= busy_reg && (cur_ctl_reg.cmd == CMD_QUERY);
        end
    end

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_ctl_reg    <= op_ctl;
            cur_height_reg <= op_height;
            cur_x_reg      <= op_x;
            cur_y_reg      <= op_y;
            cur_px_reg     <= op_px;
            cur_rx_reg     <= op_rx;
            cur_py_reg     <= op_py;
            cur_ry_reg     <= op_ry;
        end
    end

    // Token payload alongside the registered read
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_ctl_reg.first <= (step_reg == 2'd0);
            tok_ctl_reg.last  <= last_step;
            tok_ctl_reg.oor   <= cur_ctl_reg.oor;
            tok_weight_reg    <= weight;
            tok_x_reg         <= cur_x_reg;
            tok_y_reg         <= cur_y_reg;
        end
    end

    assign tok_valid  = tok_valid_reg;
    assign tok_ctl    = tok_ctl_reg;
    assign tok_weight = tok_weight_reg;
    assign tok_x      = tok_x_reg;
    assign tok_y      = tok_y_reg;

    `ASSERT_CLK(a_step_only_reads, (step_reg != 2'd0) |-> is_read,
        "step counter left zero outside an in-range query")
    `ASSERT_CLK(a_freeze_holds, !adv |=> $stable(step_reg) && $stable(pos_reg),
        "sequencer state moved while the output was stalled")
    `ASSERT_CLK(a_last_not_first,
        tok_valid_reg && tok_ctl_reg.last && !tok_ctl_reg.oor |-> !tok_ctl_reg.first,
        "query finished without reading all four neighbors")

endmodule

// ===== rtl/ttbc_blend.sv =====
// Weighted sum of the four neighbors, band compare and response register
`include "assert_macros.svh"

module ttbc_blend #(
    parameter int MAX_RES = ttbc_pkg::MAX_RES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [$clog2(MAX_RES+1)-1:0]          res,
    output logic                                  adv,
    input  logic                                  tok_valid,
    input  ttbc_pkg::ttbc_tok_ctl_t               tok_ctl,
    input  logic [2*($clog2(MAX_RES+1)+1)-1:0]    tok_weight,
    input  logic [ttbc_pkg::TEXEL_W-1:0]          tok_x,
    input  logic [ttbc_pkg::TEXEL_W-1:0]          tok_y,
    input  logic [ttbc_pkg::HEIGHT_W-1:0]         rdata,
    ttbc_rsp_if.source                            rsp
);
    import ttbc_pkg::*;

    localparam int RW = $clog2(MAX_RES + 1);
    localparam int KW = RW + 1;
    localparam int WW = 2 * KW;
    localparam int HW = HEIGHT_W + WW;

    // Scale and thresholds, derived from the resolution register
    logic [WW-1:0]      s_reg;
    logic [HW-1:0]      thr_hi_reg;
    logic [HW-1:0]      thr_mid_reg;
    logic [HW-1:0]      thr_lo_reg;

    // Product stage
    logic               p_valid_reg;
    ttbc_tok_ctl_t      p_ctl_reg;
    logic [HW-1:0]      prod_reg;
    logic [TEXEL_W-1:0] p_x_reg;
    logic [TEXEL_W-1:0] p_y_reg;

    // Accumulator and response register
    logic [HW-1:0]      acc_reg;
    logic               out_valid_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [TEXEL_W-1:0] echo_x_reg;
    logic [TEXEL_W-1:0] echo_y_reg;
    logic               oor_reg;

    logic [KW-1:0]      k;
    logic [HW-1:0]      sum;
    logic [BAND_W-1:0]  band_next;
    logic               out_load;

    // Freeze the datapath only while a response waits
    assign adv = !out_valid_reg || rsp.ready;

    // Derive (R+1)^2 and the three thresholds
    assign k = KW'(res) + 1'b1;

    always_ff @(posedge clk)
    begin
        s_reg       <= WW'(k) * WW'(k);
        thr_hi_reg  <= HW'(THR_MOUNTAIN) * HW'(s_reg);
        thr_mid_reg <= HW'(THR_GRASS) * HW'(s_reg);
        thr_lo_reg  <= HW'(THR_SAND) * HW'(s_reg);
    end

    // Weight the neighbor sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= tok_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_ctl_reg <= tok_ctl;
            prod_reg  <= HW'(rdata) * HW'(tok_weight);
            p_x_reg   <= tok_x;
            p_y_reg   <= tok_y;
        end
    end

    // Accumulate and classify on the last neighbor
    assign sum      = (p_ctl_reg.first ? '0 : acc_reg) + prod_reg;
    assign out_load = adv && p_valid_reg && p_ctl_reg.last;

    always_comb
    begin
        if (p_ctl_reg.oor)
        begin
            band_next = BAND_WATER;
        end
        else if (sum > thr_hi_reg)
        begin
            band_next = BAND_MOUNTAIN;
        end
        else if (sum > thr_mid_reg)
        begin
            band_next = BAND_GRASS;
        end
        else if (sum > thr_lo_reg)
        begin
            band_next = BAND_SAND;
        end
        else
        begin
            band_next = BAND_WATER;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && p_valid_reg)
        begin
            acc_reg <= sum;
        end
        if (out_load)
        begin
            band_reg   <= band_next;
            echo_x_reg <= p_x_reg;
            echo_y_reg <= p_y_reg;
            oor_reg    <= p_ctl_reg.oor;
        end
    end

    // Present the response until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= p_valid_reg && p_ctl_reg.last;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.band         = band_reg;
    assign rsp.echo_x       = echo_x_reg;
    assign rsp.echo_y       = echo_y_reg;
    assign rsp.out_of_range = oor_reg;

    `ASSERT_CLK(a_oor_single_token,
        tok_valid && tok_ctl.oor |-> tok_ctl.first && tok_ctl.last,
        "out-of-range query must travel as one token")

endmodule

// ===== rtl/terrain_texel_band_classifier.sv =====
// Top level of the terrain texel band classifier
//
// Channels: req (sink) carries load and query requests, rsp (source) carries
// one response per query and none per load, cfg (sink) writes side_length
// (index 0) and resolution (index 1); cfg is always ready.
// A load writes the next height sample in raster order with a single write to
// the height RAM, so loads flow at one per cycle while rsp does not stall.
// A query reads its four neighbor samples from the single-port height RAM,
// one per cycle while rsp does not stall, and the next request is taken no
// earlier than the last read; a query beyond the grid skips the reads.
// From request accept to response valid, a request passes two intake stages,
// the RAM read sequence, a product stage and the response register.
// Reset clears the pipeline and the load position and sets side_length to 64
// and resolution to 2; the height RAM is not cleared and must be loaded before
// it is queried.
// When rsp stalls, the response is held and the read sequence freezes; the two
// intake stages keep taking requests until they fill.
module terrain_texel_band_classifier #(
    parameter int MAX_SIDE = ttbc_pkg::MAX_SIDE_DEF,
    parameter int MAX_RES  = ttbc_pkg::MAX_RES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ttbc_req_if.sink   req,
    ttbc_rsp_if.source rsp,
    ttbc_cfg_if.sink   cfg
);
    import ttbc_pkg::*;

    localparam int SW       = $clog2(MAX_SIDE + 1);
    localparam int RW       = $clog2(MAX_RES + 1);
    localparam int CW       = $clog2(MAX_SIDE);
    localparam int WW       = 2 * (RW + 1);
    localparam int SIDE_RST = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;
    localparam int RES_RST  = (RES_RESET > MAX_RES) ? MAX_RES : RES_RESET;

    logic [SW-1:0]        side_reg;
    logic [SW-1:0]        side_next;
    logic [RW-1:0]        res_reg;
    logic [RW-1:0]        res_next;
    logic [SIDE_CFG_W-1:0] side_wr;
    logic [RES_CFG_W-1:0]  res_wr;

    logic                 op_valid;
    logic                 op_ready;
    ttbc_op_ctl_t         op_ctl;
    logic [HEIGHT_W-1:0]  op_height;
    logic [TEXEL_W-1:0]   op_x;
    logic [TEXEL_W-1:0]   op_y;
    logic [CW-1:0]        op_px;
    logic [RW-1:0]        op_rx;
    logic [CW-1:0]        op_py;
    logic [RW-1:0]        op_ry;

    logic                 adv;
    logic                 tok_valid;
    ttbc_tok_ctl_t        tok_ctl;
    logic [WW-1:0]        tok_weight;
    logic [TEXEL_W-1:0]   tok_x;
    logic [TEXEL_W-1:0]   tok_y;
    logic [HEIGHT_W-1:0]  rdata;

    // Decode and clamp register writes
    assign cfg.ready = 1'b1;
    assign side_wr   = cfg.data[SIDE_CFG_W-1:0];
    assign res_wr    = cfg.data[RES_CFG_W-1:0];

    always_comb
    begin
        side_next = side_reg;
        res_next  = res_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SIDE:
                begin
                    if (32'(side_wr) < 32'(SIDE_MIN))
                    begin
                        side_next = SW'(SIDE_MIN);
                    end
                    else if (32'(side_wr) > 32'(MAX_SIDE))
                    begin
                        side_next = SW'(MAX_SIDE);
                    end
                    else
                    begin
                        side_next = SW'(side_wr);
                    end
                end
                REG_RES:
                begin
                    if (32'(res_wr) < 32'(RES_MIN))
                    begin
                        res_next = RW'(RES_MIN);
                    end
                    else if (32'(res_wr) > 32'(MAX_RES))
                    begin
                        res_next = RW'(MAX_RES);
                    end
                    else
                    begin
                        res_next = RW'(res_wr);
                    end
                end
                default:
                begin
                    side_next = side_reg;
                    res_next  = res_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SW'(SIDE_RST);
            res_reg  <= RW'(RES_RST);
        end
        else
        begin
            side_reg <= side_next;
            res_reg  <= res_next;
        end
    end

    // Intake and coordinate split
    ttbc_front #(
        .MAX_SIDE (MAX_SIDE),
        .MAX_RES  (MAX_RES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .side      (side_reg),
        .res       (res_reg),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op_ctl    (op_ctl),
        .op_height (op_height),
        .op_x      (op_x),
        .op_y      (op_y),
        .op_px     (op_px),
        .op_rx     (op_rx),
        .op_py     (op_py),
        .op_ry     (op_ry)
    );

    // Height store and neighbor read sequence
    ttbc_seq #(
        .MAX_SIDE (MAX_SIDE),
        .MAX_RES  (MAX_RES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .side       (side_reg),
        .res        (res_reg),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op_ctl     (op_ctl),
        .op_height  (op_height),
        .op_x       (op_x),
        .op_y       (op_y),
        .op_px      (op_px),
        .op_rx      (op_rx),
        .op_py      (op_py),
        .op_ry      (op_ry),
        .adv        (adv),
        .tok_valid  (tok_valid),
        .tok_ctl    (tok_ctl),
        .tok_weight (tok_weight),
        .tok_x      (tok_x),
        .tok_y      (tok_y),
        .rdata      (rdata)
    );

    // Blend, classify and respond
    ttbc_blend #(
        .MAX_RES (MAX_RES)
    ) u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res_reg),
        .adv        (adv),
        .tok_valid  (tok_valid),
        .tok_ctl    (tok_ctl),
        .tok_weight (tok_weight),
        .tok_x      (tok_x),
        .tok_y      (tok_y),
        .rdata      (rdata),
        .rsp        (rsp)
    );

endmodule

// ===== test/terrain_texel_band_classifier_test.sv =====
// Testbench for the texel band classifier: random and directed requests against a predictor
module terrain_texel_band_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ttbc_pkg::*;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int MAP_ENTRIES    = MAX_SIDE_DEF * MAX_SIDE_DEF;
    localparam int FILL_LOADS     = 3 * MAX_SIDE_DEF;
    localparam int RANDOM_PER_SET = 50;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic                cmd;
        logic [HEIGHT_W-1:0] height;
        logic [TEXEL_W-1:0]  texel_x;
        logic [TEXEL_W-1:0]  texel_y;
    } texel_request_t;

    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [TEXEL_W-1:0] echo_x;
        logic [TEXEL_W-1:0] echo_y;
        logic               out_of_range;
    } band_answer_t;

    // Band predictor: own copy of the height map, load position and registers
    class band_scoreboard;
        logic [SIDE_CFG_W-1:0] side_reg;
        logic [RES_CFG_W-1:0]  res_reg;
        logic [HEIGHT_W-1:0]   height_map [MAP_ENTRIES];
        bit                    written [MAP_ENTRIES];
        int unsigned           load_slot;
        band_answer_t          answers_due [$];
        int                    failures;

        function new();
            side_reg  = SIDE_CFG_W'(SIDE_RESET);
            res_reg   = RES_CFG_W'(RES_RESET);
            load_slot = 0;
            failures  = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == REG_SIDE)
                side_reg = data[SIDE_CFG_W-1:0];
            else if (index == REG_RES)
                res_reg = data[RES_CFG_W-1:0];
        endfunction

        function int unsigned map_side();
            if (side_reg < SIDE_MIN)
                return SIDE_MIN;
            if (side_reg > MAX_SIDE_DEF)
                return MAX_SIDE_DEF;
            return 32'(side_reg);
        endfunction

        function int unsigned texel_step();
            if (res_reg < RES_MIN)
                return RES_MIN;
            if (res_reg > MAX_RES_DEF)
                return MAX_RES_DEF;
            return 32'(res_reg);
        endfunction

        function int unsigned grid_side();
            return (map_side() - 1) * texel_step() + 1;
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        // Leading rows of the current map that hold loaded samples only
        function int unsigned written_rows();
            int unsigned side, rows;
            bit full;
            side = map_side();
            rows = 0;
            full = 1'b1;
            while (full && rows < side) begin
                for (int unsigned col = 0; col < side; col++)
                    if (!written[rows * side + col])
                        full = 1'b0;
                if (full)
                    rows++;
            end
            return rows;
        endfunction

        // A texel beyond the grid, or one whose four neighbors are all loaded
        function bit texel_safe(int unsigned x, int unsigned y);
            int unsigned side, step, px, py, nx, ny;
            side = map_side();
            step = texel_step();
            if (x >= grid_side() || y >= grid_side())
                return 1'b1;
            px = x / step;
            py = y / step;
            nx = (px + 1 < side) ? px + 1 : side - 1;
            ny = (py + 1 < side) ? py + 1 : side - 1;
            return written[px + py * side] && written[nx + py * side]
                && written[px + ny * side] && written[nx + ny * side];
        endfunction

        // Store a sample, or work out the band of a queried texel
        function void note_request(texel_request_t r);
            int unsigned side, step, total, grid, x, y;
            int unsigned px, py, rx, ry, nx, ny, k, s, h;
            int unsigned a, b, c, d;
            band_answer_t ans;
            side = map_side();
            step = texel_step();
            if (r.cmd == CMD_LOAD) begin
                total = side * side;
                if (load_slot >= total)
                    load_slot = 0;
                height_map[load_slot] = r.height;
                written[load_slot] = 1'b1;
                load_slot++;
                if (load_slot >= total)
                    load_slot = 0;
                return;
            end
            grid = (side - 1) * step + 1;
            x = 32'(r.texel_x);
            y = 32'(r.texel_y);
            ans.echo_x = r.texel_x;
            ans.echo_y = r.texel_y;
            ans.band = BAND_WATER;
            ans.out_of_range = (x >= grid) || (y >= grid);
            if (!ans.out_of_range) begin
                px = x / step;
                rx = x % step;
                py = y / step;
                ry = y % step;
                nx = (px + 1 < side) ? px + 1 : side - 1;
                ny = (py + 1 < side) ? py + 1 : side - 1;
                k = step + 1;
                s = k * k;
                a = 32'(height_map[px + py * side]);
                b = 32'(height_map[nx + py * side]);
                c = 32'(height_map[px + ny * side]);
                d = 32'(height_map[nx + ny * side]);
                h = a * (k - rx) * (k - ry) + b * rx * (k - ry)
                  + c * (k - rx) * ry + d * rx * ry;
                if (h > THR_MOUNTAIN * s)
                    ans.band = BAND_MOUNTAIN;
                else if (h > THR_GRASS * s)
                    ans.band = BAND_GRASS;
                else if (h > THR_SAND * s)
                    ans.band = BAND_SAND;
            end
            answers_due.push_back(ans);
        endfunction

        function void report(string what);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%t: %s", $realtime, what);
        endfunction

        // Compare a response with the oldest expected band
        function void check_answer(band_answer_t got);
            band_answer_t want;
            if (answers_due.size() == 0) begin
                report($sformatf("unexpected response: band %0d x %0d y %0d oor %0b",
                                 got.band, got.echo_x, got.echo_y, got.out_of_range));
                return;
            end
            want = answers_due.pop_front();
            if (got.band !== want.band || got.echo_x !== want.echo_x ||
                got.echo_y !== want.echo_y || got.out_of_range !== want.out_of_range)
                report($sformatf({"response mismatch: expected band %0d x %0d y %0d oor %0b,",
                                  " got band %0d x %0d y %0d oor %0b"},
                                 want.band, want.echo_x, want.echo_y, want.out_of_range,
                                 got.band, got.echo_x, got.echo_y, got.out_of_range));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    band_scoreboard sb;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    int unsigned    hold_request;

    ttbc_req_if req_ch ();
    ttbc_rsp_if rsp_ch ();
    ttbc_cfg_if cfg_ch ();

    terrain_texel_band_classifier dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    // Run limit
    initial
    begin
        #2_000_000;
        $display("terrain_texel_band_classifier_test: FAIL");
        $finish;
    end

    // Drive response ready: random stalls, plus a long hold when asked
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every accepted response
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_answer(band_answer_t'{band: rsp_ch.band, echo_x: rsp_ch.echo_x,
                                           echo_y: rsp_ch.echo_y,
                                           out_of_range: rsp_ch.out_of_range});
    end

    // Offer one request after random idle cycles and hold it until accepted
    task automatic send_request(input texel_request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= r.cmd;
        req_ch.height  <= r.height;
        req_ch.texel_x <= r.texel_x;
        req_ch.texel_y <= r.texel_y;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(r);
    endtask

    task automatic load_height(input int unsigned h);
        texel_request_t r;
        r.cmd     = CMD_LOAD;
        r.height  = HEIGHT_W'(h);
        r.texel_x = TEXEL_W'($urandom_range(511));
        r.texel_y = TEXEL_W'($urandom_range(511));
        send_request(r);
    endtask

    // Drop a query whose neighbors are not all loaded yet
    task automatic query_texel(input int unsigned x, input int unsigned y);
        texel_request_t r;
        if (!sb.texel_safe(x, y))
            return;
        r.cmd     = CMD_QUERY;
        r.height  = HEIGHT_W'($urandom_range(255));
        r.texel_x = TEXEL_W'(x);
        r.texel_y = TEXEL_W'(y);
        send_request(r);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.write_register(index, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid, wait for every band due, then let trailing loads retire
    task automatic drain_block();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Mix of loads, in-grid queries over loaded rows and queries beyond the grid
    task automatic random_requests(input int count);
        int unsigned grid, step, rows, y_top, pick;
        grid = sb.grid_side();
        step = sb.texel_step();
        repeat (count)
        begin
            pick = $urandom_range(99);
            rows = sb.written_rows();
            if (rows >= sb.map_side())
                y_top = grid - 1;
            else if (rows >= 2)
                y_top = (rows - 1) * step - 1;
            else
                y_top = 0;
            if (pick < 40 || rows < 2)
                load_height($urandom_range(255));
            else if (pick < 52)
            begin
                if ($urandom_range(1) == 0)
                    query_texel($urandom_range(511, grid), $urandom_range(511));
                else
                    query_texel($urandom_range(511), $urandom_range(511, grid));
            end
            else
                query_texel($urandom_range(grid - 1), $urandom_range(y_top));
        end
    endtask

    // Reconfigure, probe the grid corners and edges, then run random requests
    task automatic run_setting(input logic [CFG_DATA_W-1:0] side_data,
                               input logic [CFG_DATA_W-1:0] res_data,
                               input int unsigned hold_cycles);
        int unsigned grid;
        drain_block();
        write_register(REG_SIDE, side_data);
        write_register(REG_RES, res_data);
        grid = sb.grid_side();
        query_texel(0, 0);
        query_texel(grid - 1, grid - 1);
        query_texel(grid, 0);
        query_texel(0, grid);
        hold_request = hold_cycles;
        random_requests(RANDOM_PER_SET);
    endtask

    initial
    begin
        texel_request_t idle_req;
        logic [HEIGHT_W-1:0] edge_heights [8];
        int unsigned step;
        sb = new();
        edge_heights = '{HEIGHT_W'(0), HEIGHT_W'(255),
                         HEIGHT_W'(THR_MOUNTAIN), HEIGHT_W'(THR_MOUNTAIN + 1),
                         HEIGHT_W'(THR_GRASS), HEIGHT_W'(THR_GRASS + 1),
                         HEIGHT_W'(THR_SAND), HEIGHT_W'(THR_SAND + 1)};
        idle_req = '0;
        rst_n = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.cmd     = idle_req.cmd;
        req_ch.height  = idle_req.height;
        req_ch.texel_x = idle_req.texel_x;
        req_ch.texel_y = idle_req.texel_y;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SIDE;
        cfg_ch.data  = '0;
        hold_request  = 0;
        send_idle_pct = 26;
        recv_idle_pct = 68;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Place extreme and threshold heights on row 0, then fill the first rows
        foreach (edge_heights[i])
            load_height(edge_heights[i]);
        repeat (FILL_LOADS - 8) load_height($urandom_range(255));

        // Hit the threshold heights on sample points
        step = sb.texel_step();
        foreach (edge_heights[i])
            query_texel(i * step, 0);
        query_texel(1, 1);
        query_texel(step + 1, 0);
        query_texel(sb.grid_side() - 1, sb.grid_side() - 1);
        query_texel(sb.grid_side() - 1, 0);
        query_texel(sb.grid_side(), 0);
        query_texel(0, sb.grid_side());
        query_texel(511, 511);
        random_requests(RANDOM_PER_SET);

        // Writes to unused indexes must change nothing
        drain_block();
        write_register(REG_SPARE_A, 7'h7F);
        write_register(REG_SPARE_B, 7'h01);
        run_setting(7'd2, 7'd1, 0);
        run_setting(7'd64, 7'd8, 0);

        send_idle_pct = 68;
        recv_idle_pct = 26;
        run_setting(7'd0, 7'd0, 0);
        run_setting(7'd127, 7'h7F, 0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(7'd5, 7'd3, 250);
        run_setting(7'd17, 7'd7, 0);

        drain_block();
        repeat (8) @(posedge clk);
        if (sb.failures == 0)
            $display("terrain_texel_band_classifier_test: PASS");
        else
            $display("terrain_texel_band_classifier_test: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ttbc_pkg.sv
rtl/ttbc_ifs.sv
rtl/ttbc_ram.sv
rtl/ttbc_front.sv
rtl/ttbc_seq.sv
rtl/ttbc_blend.sv
rtl/terrain_texel_band_classifier.sv
test/terrain_texel_band_classifier_test.sv
